FILE: rtl/cnlc_pkg.sv
// cnlc_pkg: shared types, constants and helpers for the card number Luhn classifier.
// Holds the double-dabble step, the Luhn digit map and the mod-10 test.
// No dependencies.
package cnlc_pkg;

  localparam int VALUE_W     = 63;                       // input field width
  localparam int DIG_N       = 19;                       // decimal digits of a 63-bit value
  localparam int BCD_W       = 4 * DIG_N;
  localparam int BIN_W       = 64;                       // value padded to a stage multiple
  localparam int BITS_PER_STG = 8;
  localparam int NCONV       = BIN_W / BITS_PER_STG;     // conversion stages
  localparam int NGRP        = 4;                        // Luhn partial-sum groups
  localparam int GRP_DIG     = 5;                        // digits per group
  localparam int MIN_DIGITS  = 13;

  localparam logic [1:0] BRAND_NONE  = 2'd0;
  localparam logic [1:0] BRAND_LEAD4 = 2'd1;
  localparam logic [1:0] BRAND_3437  = 2'd2;
  localparam logic [1:0] BRAND_5155  = 2'd3;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;   // bits not yet shifted in, MSB first
  } conv_t;

  typedef struct packed {
    logic [4:0]            cnt;
    logic [3:0]            hi;   // leading digit
    logic [3:0]            lo;   // digit after the leading one
    logic [NGRP-1:0][5:0]  grp;  // Luhn partial sums
  } l1_t;

  typedef struct packed {
    logic [4:0] cnt;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       ok;
  } l2_t;

  // One double-dabble step: adjust every digit, shift in one binary bit.
  function automatic logic [BCD_W-1:0] dabble_step(logic [BCD_W-1:0] bcd, logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIG_N; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // One conversion stage: BITS_PER_STG dabble steps.
  function automatic conv_t conv_stage(conv_t c);
    conv_t r;
    r = c;
    for (int j = 0; j < BITS_PER_STG; j++) begin
      r.bcd = dabble_step(r.bcd, r.bin[BIN_W-1]);
      r.bin = {r.bin[BIN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Luhn contribution of one digit; doubled digits fold to their digit sum.
  function automatic logic [3:0] luhn_term(logic [3:0] d, logic dbl);
    logic [4:0] t;
    t = dbl ? {d, 1'b0} : {1'b0, d};
    if (t >= 5'd10) t = t - 5'd9;
    return t[3:0];
  endfunction

  // True when s is a multiple of ten (s <= 171).
  function automatic logic is_mod10(logic [7:0] s);
    logic [7:0] r;
    r = s;
    if (r >= 8'd160) r = r - 8'd160;
    if (r >= 8'd80)  r = r - 8'd80;
    if (r >= 8'd40)  r = r - 8'd40;
    if (r >= 8'd20)  r = r - 8'd20;
    if (r >= 8'd10)  r = r - 8'd10;
    return (r == 8'd0);
  endfunction

endpackage

FILE: rtl/card_number_luhn_classifier.sv
// card_number_luhn_classifier: pipelined binary-to-decimal conversion, Luhn mod-10 check
// and brand classification of a card number. Depends on cnlc_pkg.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_card_value[62:0]        | in
//  result  | out_valid, out_stall, out_brand_code[1:0],     | out
//          | out_checksum_ok, out_digit_count[4:0]          |
//
// One transfer per clock in each direction when nothing stalls. The pipeline has
// eight double-dabble stages of 8 bits each, a digit scan / partial Luhn sum stage,
// a total sum / mod-10 stage and the result register.
// Reset (rst_n low, synchronous) empties every stage; payload registers are not reset.
// A stall on the result side fills empty stages first; in_stall rises only when
// every stage from the front to the stalled result holds an item.
module card_number_luhn_classifier #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cnlc_pkg::VALUE_W-1:0] in_card_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_brand_code,
  output logic                         out_checksum_ok,
  output logic [4:0]                   out_digit_count
);
  import cnlc_pkg::*;

  localparam int NSTG  = NCONV + 3;   // conversion, scan, sum, result
  localparam int S_L1  = NCONV;
  localparam int S_L2  = NCONV + 1;
  localparam int S_OUT = NCONV + 2;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;   // stage may load this cycle

  conv_t conv_r [NCONV];
  l1_t   l1_r;
  l2_t   l2_r;
  logic [1:0] brand_r;
  logic       ok_r;
  logic [4:0] cnt_r;

  // Bubble-collapsing advance: a stage loads when empty or when its content moves on.
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG-2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Double-dabble conversion, 8 input bits per stage. The padding zero at the top
  // of the 64-bit word shifts into an all-zero BCD register and changes nothing.
  for (genvar k = 0; k < NCONV; k++) begin : g_conv
    conv_t src;
    if (k == 0) begin : g_first
      assign src = '{bcd: '0, bin: {{(BIN_W-VALUE_W){1'b0}}, in_card_value}};
    end else begin : g_next
      assign src = conv_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (rdy[k]) conv_r[k] <= conv_stage(src);
    end
  end

  // Scan stage: digit count, two leading digits, Luhn partial sums.
  // Digit i (from the right, from 0) is doubled when i is odd.
  l1_t l1_nxt;
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [3:0]       d;
    b = conv_r[NCONV-1].bcd;
    l1_nxt = '0;
    for (int i = 0; i < DIG_N; i++) begin
      d = b[4*i +: 4];
      if (d != 4'd0) begin
        l1_nxt.cnt = 5'(i + 1);
        l1_nxt.hi  = d;
      end
    end
    // digit below the leading one; stays zero for a single-digit value
    for (int i = 1; i < DIG_N; i++) begin
      if (b[4*i +: 4] != 4'd0) l1_nxt.lo = b[4*(i-1) +: 4];
    end
    for (int g = 0; g < NGRP; g++) begin
      for (int j = 0; j < GRP_DIG; j++) begin
        if (g*GRP_DIG + j < DIG_N) begin
          l1_nxt.grp[g] = l1_nxt.grp[g] +
            6'(luhn_term(b[4*(g*GRP_DIG+j) +: 4], ((g*GRP_DIG + j) % 2) == 1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_L1]) l1_r <= l1_nxt;
  end

  // Sum stage: total Luhn sum and mod-10 test.
  l2_t l2_nxt;
  always_comb begin
    logic [7:0] tot;
    tot = '0;
    for (int g = 0; g < NGRP; g++) tot = tot + 8'(l1_r.grp[g]);
    l2_nxt.cnt = l1_r.cnt;
    l2_nxt.hi  = l1_r.hi;
    l2_nxt.lo  = l1_r.lo;
    l2_nxt.ok  = is_mod10(tot);
  end

  always_ff @(posedge clk) begin
    if (rdy[S_L2]) l2_r <= l2_nxt;
  end

  // Classification. A value wider than MAX_DIGITS reports all zeros.
  logic [1:0] brand_nxt;
  logic       ok_nxt;
  logic [4:0] cnt_nxt;
  always_comb begin
    logic ovf;
    ovf       = l2_r.cnt > 5'(MAX_DIGITS);
    brand_nxt = BRAND_NONE;
    ok_nxt    = ovf ? 1'b0 : l2_r.ok;
    cnt_nxt   = ovf ? 5'd0 : l2_r.cnt;
    if (!ovf && l2_r.ok && l2_r.cnt >= 5'(MIN_DIGITS)) begin
      priority if ((l2_r.cnt == 5'd13 || l2_r.cnt == 5'd16) && l2_r.hi == 4'd4) begin
        brand_nxt = BRAND_LEAD4;
      end else if (l2_r.cnt == 5'd15 && l2_r.hi == 4'd3 &&
                   (l2_r.lo == 4'd4 || l2_r.lo == 4'd7)) begin
        brand_nxt = BRAND_3437;
      end else if (l2_r.cnt == 5'd16 && l2_r.hi == 4'd5 &&
                   l2_r.lo >= 4'd1 && l2_r.lo <= 4'd5) begin
        brand_nxt = BRAND_5155;
      end else begin
        brand_nxt = BRAND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      brand_r <= brand_nxt;
      ok_r    <= ok_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid       = vld_r[S_OUT];
  assign out_brand_code  = brand_r;
  assign out_checksum_ok = ok_r;
  assign out_digit_count = cnt_r;

  // A brand is only given to a number that passes the check with 13 to 16 digits.
  a_brand_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brand_code != BRAND_NONE |->
      out_checksum_ok && out_digit_count >= 5'd13 && out_digit_count <= 5'd16)
    else $error("brand reported without passing checksum or length");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_count <= 5'(MAX_DIGITS))
    else $error("digit count above converter range");

  // Input is held off only when the front stage is full and cannot drain.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0] && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // An item taken from the result register is replaced by the one behind it.
  a_drain_refill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && vld_r[S_L2] |=> out_valid)
    else $error("result register lost an item");

endmodule

FILE: test/card_number_luhn_classifier_checker.sv
// card_number_luhn_classifier_checker: watches the input and result channels of the classifier,
// predicts each result from the accepted card number and compares the results in order.
// Depends on cnlc_pkg for the field width, the brand codes and the minimum brand length.
module card_number_luhn_classifier_checker #(
  parameter int MAX_DIGITS = 19
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [cnlc_pkg::VALUE_W-1:0] in_card_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [1:0]                   out_brand_code,
  input  logic                         out_checksum_ok,
  input  logic [4:0]                   out_digit_count,
  output int                           fail_count,
  output int                           pending,
  output int                           checked,
  output int                           branded
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SHOWN = 40;   // cap on printed mismatches

  typedef struct packed {
    logic [1:0] brand;
    logic       ok;
    logic [4:0] ndig;
  } card_verdict_t;

  card_verdict_t verdicts_due[$];
  int n_fail;
  int n_checked;
  int n_branded;

  // Digit split, Luhn sum and brand decision for one card number.
  function automatic card_verdict_t classify_card(logic [cnlc_pkg::VALUE_W-1:0] value);
    card_verdict_t r;
    longint unsigned v;
    int unsigned nd, sum, raw, d, hi, lo;
    v = {1'b0, value};
    nd = 0;
    sum = 0;
    hi = 0;
    lo = 0;
    while (v != 0) begin
      raw = 32'(v % 10);
      v = v / 10;
      d = raw;
      if (nd % 2 == 1) begin
        d = 2 * d;
        if (d > 9) d = d - 9;
      end
      sum += d;
      lo = hi;
      hi = raw;
      nd++;
    end
    r = '0;
    if (nd > MAX_DIGITS) return r;   // out of converter range: all zero
    r.ok = (sum % 10 == 0);
    r.ndig = nd[4:0];
    r.brand = cnlc_pkg::BRAND_NONE;
    if (value != 0 && nd >= cnlc_pkg::MIN_DIGITS && r.ok) begin
      if ((nd == 13 || nd == 16) && hi == 4)
        r.brand = cnlc_pkg::BRAND_LEAD4;
      else if (nd == 15 && hi == 3 && (lo == 4 || lo == 7))
        r.brand = cnlc_pkg::BRAND_3437;
      else if (nd == 16 && hi == 5 && lo >= 1 && lo <= 5)
        r.brand = cnlc_pkg::BRAND_5155;
    end
    return r;
  endfunction

  task automatic flag(input string what, input int unsigned want_v, input int unsigned got_v);
    n_fail++;
    if (n_fail <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    card_verdict_t want;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (verdicts_due.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_SHOWN)
            $display("%0t: result with none expected: expected nothing, got brand %0d ok %0d digits %0d",
                     $time, out_brand_code, out_checksum_ok, out_digit_count);
        end else begin
          want = verdicts_due.pop_front();
          n_checked++;
          if (want.brand != cnlc_pkg::BRAND_NONE) n_branded++;
          if (out_brand_code !== want.brand)
            flag("brand_code", 32'(want.brand), 32'(out_brand_code));
          if (out_checksum_ok !== want.ok)
            flag("checksum_ok", 32'(want.ok), 32'(out_checksum_ok));
          if (out_digit_count !== want.ndig)
            flag("digit_count", 32'(want.ndig), 32'(out_digit_count));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        verdicts_due.push_back(classify_card(in_card_value));
    end
    fail_count <= n_fail;
    pending    <= verdicts_due.size();
    checked    <= n_checked;
    branded    <= n_branded;
  end

endmodule

FILE: test/card_number_luhn_classifier_test.sv
// card_number_luhn_classifier_test: stimulus and verdict for the card number Luhn classifier.
// Depends on cnlc_pkg, the block under test and card_number_luhn_classifier_checker.
module card_number_luhn_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest stalled run
  localparam int RANDOM_CARDS = 1080;
  localparam int CALM_FROM    = RANDOM_CARDS - 150;  // no idling over the tail
  localparam int TAIL_CYCLES  = 24;      // idle wait after the final drain

  // Shapes of random stimulus.
  typedef enum int {MIX_BRAND, MIX_NEAR, MIX_ANY_LEN, MIX_RAW} card_mix_t;
  typedef enum int {SHAPE_LEAD4, SHAPE_3437, SHAPE_5155} card_shape_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [cnlc_pkg::VALUE_W-1:0] in_card_value;
  logic                         out_valid;
  logic                         out_stall;
  logic [1:0]                   out_brand_code;
  logic                         out_checksum_ok;
  logic [4:0]                   out_digit_count;

  int fail_count;
  int pending;
  int checked;
  int branded;
  int sent;
  int directed_n;
  int cycles;
  bit idle_on;

  card_number_luhn_classifier u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_card_value  (in_card_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_brand_code (out_brand_code),
    .out_checksum_ok(out_checksum_ok),
    .out_digit_count(out_digit_count)
  );

  // The checker sees both channels and owns every comparison; the top only reads its counts.
  card_number_luhn_classifier_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_card_value  (in_card_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_brand_code (out_brand_code),
    .out_checksum_ok(out_checksum_ok),
    .out_digit_count(out_digit_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked),
    .branded        (branded)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts while idling is on.
  // Lowering and the next decision sit on different edges, so stall never glitches.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Builds a card number from a leading prefix and random digits, most significant first.
  // With make_valid the last digit is the Luhn check digit; spoil bumps it so the sum fails.
  // Callers keep 19-digit numbers below 9 at the front so the value fits in 63 bits.
  function automatic logic [cnlc_pkg::VALUE_W-1:0] card_from_digits(
      input int len, input int unsigned prefix, input int plen,
      input bit make_valid, input bit spoil);
    int unsigned dig[19];
    int unsigned p, s, t;
    longint unsigned v;
    p = prefix;
    s = 0;
    v = 0;
    for (int i = 0; i < len; i++) dig[i] = $urandom_range(0, 9);
    for (int i = plen - 1; i >= 0; i--) begin
      dig[i] = p % 10;
      p = p / 10;
    end
    if (make_valid) begin
      // position counted from the right; odd positions get doubled
      for (int i = 0; i < len - 1; i++) begin
        t = dig[i];
        if ((len - 1 - i) % 2 == 1) begin
          t = 2 * t;
          if (t > 9) t = t - 9;
        end
        s += t;
      end
      dig[len - 1] = (10 - s % 10) % 10;
    end
    if (spoil) dig[len - 1] = (dig[len - 1] + 1) % 10;
    for (int i = 0; i < len; i++) v = v * 10 + dig[i];
    return v[cnlc_pkg::VALUE_W-1:0];
  endfunction

  // Mostly well-formed brand candidates with random body digits, the rest near misses,
  // numbers of any length and raw binary values.
  function automatic logic [cnlc_pkg::VALUE_W-1:0] random_card();
    card_mix_t mix;
    card_shape_t shape;
    int unsigned pick;
    int len;
    logic [63:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 55)      mix = MIX_BRAND;
    else if (pick < 70) mix = MIX_NEAR;
    else if (pick < 85) mix = MIX_ANY_LEN;
    else                mix = MIX_RAW;
    case (mix)
      MIX_BRAND: begin
        shape = card_shape_t'($urandom_range(0, 2));
        // roughly one in seven brand candidates carries a broken check digit
        case (shape)
          SHAPE_LEAD4: return card_from_digits($urandom_range(0, 1) ? 16 : 13, 4, 1, 1'b1,
                                               $urandom_range(0, 6) == 0);
          SHAPE_3437:  return card_from_digits(15, $urandom_range(0, 1) ? 37 : 34, 2, 1'b1,
                                               $urandom_range(0, 6) == 0);
          default:     return card_from_digits(16, $urandom_range(51, 55), 2, 1'b1,
                                               $urandom_range(0, 6) == 0);
        endcase
      end
      MIX_NEAR: begin
        // valid checksum, but length or prefix may be just off
        return card_from_digits($urandom_range(12, 17), $urandom_range(30, 59), 2, 1'b1, 1'b0);
      end
      MIX_ANY_LEN: begin
        len = $urandom_range(1, 19);
        return card_from_digits(len, $urandom_range(1, len == 19 ? 8 : 9), 1,
                                $urandom_range(0, 1) == 1, 1'b0);
      end
      default: begin
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 1)) raw = raw >> $urandom_range(1, 63);
        return raw[cnlc_pkg::VALUE_W-1:0];
      end
    endcase
  endfunction

  // One transfer on the input channel, with an optional idle burst ahead of it.
  task automatic send_card(input logic [cnlc_pkg::VALUE_W-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_card_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Hold the input side until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_card_value = '0;
    idle_on       = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed edge cases: value extremes, bit patterns, each brand and its near misses.
    send_card('0);                                  // zero: no digits, sum passes, no brand
    send_card(63'd1);
    send_card(63'd9);
    send_card({cnlc_pkg::VALUE_W{1'b1}});           // largest value, 19 digits
    send_card(63'h2AAA_AAAA_AAAA_AAAA);
    send_card(63'h5555_5555_5555_5555);
    send_card(63'd1000000000000000000);             // smallest 19-digit value
    send_card(63'd999999999999999999);              // largest 18-digit value
    send_card(card_from_digits(12, 4, 1, 1'b1, 1'b0));   // too short for any brand
    send_card(card_from_digits(13, 4, 1, 1'b1, 1'b0));
    send_card(card_from_digits(13, 5, 1, 1'b1, 1'b0));   // 13 digits but wrong lead
    send_card(card_from_digits(14, 4, 1, 1'b1, 1'b0));
    send_card(card_from_digits(16, 4, 1, 1'b1, 1'b0));
    send_card(card_from_digits(16, 4, 1, 1'b1, 1'b1));   // failed checksum
    send_card(card_from_digits(15, 34, 2, 1'b1, 1'b0));
    send_card(card_from_digits(15, 37, 2, 1'b1, 1'b0));
    send_card(card_from_digits(15, 35, 2, 1'b1, 1'b0));
    send_card(card_from_digits(16, 34, 2, 1'b1, 1'b0));
    send_card(card_from_digits(16, 51, 2, 1'b1, 1'b0));
    send_card(card_from_digits(16, 55, 2, 1'b1, 1'b0));
    send_card(card_from_digits(16, 50, 2, 1'b1, 1'b0));
    send_card(card_from_digits(16, 56, 2, 1'b1, 1'b0));
    send_card(card_from_digits(15, 52, 2, 1'b1, 1'b0));
    send_card(card_from_digits(19, 4, 1, 1'b1, 1'b0));
    directed_n = sent;

    // Let the pipeline run dry once before the random part.
    drain_results();

    for (int n = 0; n < RANDOM_CARDS; n++) begin
      // an idle-free stretch mid-run, and none at all over the tail
      idle_on = !(n >= 400 && n < 500) && (n < CALM_FROM);
      if (n == 700) drain_results();
      send_card(random_card());
    end
    in_valid <= 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Drove %0d card numbers: %0d directed edge cases, then brand-shaped, near-miss,",
             sent, directed_n);
    $display("any-length and raw 63-bit values; %0d results compared, %0d carrying a brand.",
             checked, branded);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cnlc_pkg.sv
rtl/card_number_luhn_classifier.sv
test/card_number_luhn_classifier_checker.sv
test/card_number_luhn_classifier_test.sv
